>>> src/hjg_pkg.sv
// ----------------------------------------------------------------------------
// hjg_pkg: shared types and constants of the halton jitter generator
// Field widths, parameter defaults, the command bundle from the controller
// to the datapath, and the ternary digit count helper.
// ----------------------------------------------------------------------------
`default_nettype none

package hjg_pkg;

  // fixed field widths
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // parameter defaults
  localparam int unsigned INDEX_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;    // take a new frame number
    logic conv_step;  // one binary-to-ternary doubling step
    logic frac_step;  // one fraction bit for x and y
    logic load_out;   // move the finished pair into the output register
  } hjg_cmd_t;

  // number of ternary digits that hold any value up to 2^bits
  function automatic int unsigned ternary_digits(input int unsigned bits);
    longint unsigned pw;
    longint unsigned lim;
    int unsigned     nd;
    pw  = 64'd1;
    lim = 64'd1 << bits;
    nd  = 0;
    while (pw <= lim) begin
      pw = pw * 64'd3;
      nd = nd + 1;
    end
    return nd;
  endfunction

endpackage

`default_nettype wire

>>> src/hjg_ctrl.sv
// ----------------------------------------------------------------------------
// hjg_ctrl: sequencer of the halton jitter generator
// Steps the datapath through the base conversion and the fraction phase,
// and owns the input ready and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hjg_ctrl #(
  parameter int unsigned INDEX_BITS = hjg_pkg::INDEX_BITS_DEF,
  parameter int unsigned FRAC_BITS  = hjg_pkg::FRAC_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output hjg_pkg::hjg_cmd_t     cmd_o
);
  import hjg_pkg::*;

  localparam int unsigned IdxW   = INDEX_BITS + 1;
  localparam int unsigned CntMax = (IdxW > FRAC_BITS) ? IdxW : FRAC_BITS;
  localparam int unsigned CntW   = $clog2(CntMax);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_FRAC = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = CntW'(IdxW - 1);
          state_d       = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CntW'(FRAC_BITS - 1);
          state_d = S_FRAC;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      S_FRAC: begin
        cmd_o.frac_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_LOAD;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> src/hjg_dpath.sv
// ----------------------------------------------------------------------------
// hjg_dpath: datapath of the halton jitter generator
// Converts the index to ternary by doubling, then doubles the digit-reversed
// ternary fraction to peel off binary fraction bits; x bits come straight
// from the index. One shared ternary doubling unit serves both phases.
// ----------------------------------------------------------------------------
`default_nettype none

module hjg_dpath #(
  parameter int unsigned INDEX_BITS = hjg_pkg::INDEX_BITS_DEF,
  parameter int unsigned FRAC_BITS  = hjg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire hjg_pkg::hjg_cmd_t                   cmd_i,
  input  wire logic        [hjg_pkg::FRAME_W-1:0]  frame_number_i,
  output logic signed      [hjg_pkg::OUT_W-1:0]    jitter_x_o,
  output logic signed      [hjg_pkg::OUT_W-1:0]    jitter_y_o
);
  import hjg_pkg::*;

  localparam int unsigned IdxW  = INDEX_BITS + 1;
  localparam int unsigned NDig  = ternary_digits(INDEX_BITS);
  localparam logic [FRAC_BITS-1:0] Half = {1'b1, {(FRAC_BITS - 1){1'b0}}};

  logic [IdxW-1:0]      n_q, n_d;
  logic [1:0]           tern_q [NDig];
  logic [1:0]           tern_d [NDig];
  logic [1:0]           dbl_in [NDig];
  logic [1:0]           dbl_res [NDig];
  logic                 dbl_cin;
  logic                 dbl_cout;
  logic [FRAC_BITS-1:0] x_acc_q, x_acc_d;
  logic [FRAC_BITS-1:0] y_acc_q, y_acc_d;
  logic [FRAC_BITS-1:0] x_ctr;
  logic [FRAC_BITS-1:0] y_ctr;
  logic signed [OUT_W-1:0] jx_q, jy_q;

  // operand order: natural for conversion, reversed for the fraction
  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      dbl_in[i] = cmd_i.frac_step ? tern_q[NDig-1-i] : tern_q[i];
    end
    dbl_cin = cmd_i.frac_step ? 1'b0 : n_q[IdxW-1];
  end

  // ternary doubling with carry in: digit 0 least significant
  always_comb begin
    logic       c;
    logic [2:0] s;
    c = dbl_cin;
    for (int i = 0; i < NDig; i++) begin
      s = {dbl_in[i], 1'b0} + {2'b00, c};
      if (s >= 3'd3) begin
        dbl_res[i] = 2'(s - 3'd3);
        c          = 1'b1;
      end else begin
        dbl_res[i] = s[1:0];
        c          = 1'b0;
      end
    end
    dbl_cout = c;
  end

  // next values of the working registers
  always_comb begin
    n_d     = n_q;
    x_acc_d = x_acc_q;
    y_acc_d = y_acc_q;
    for (int i = 0; i < NDig; i++) begin
      tern_d[i] = tern_q[i];
    end
    if (cmd_i.load_in) begin
      n_d = IdxW'(INDEX_BITS'(frame_number_i)) + IdxW'(1);
      for (int i = 0; i < NDig; i++) begin
        tern_d[i] = 2'd0;
      end
    end else if (cmd_i.conv_step) begin
      // msb first; after IdxW rotations the index is back in place
      n_d = {n_q[IdxW-2:0], n_q[IdxW-1]};
      for (int i = 0; i < NDig; i++) begin
        tern_d[i] = dbl_res[i];
      end
    end else if (cmd_i.frac_step) begin
      n_d     = {1'b0, n_q[IdxW-1:1]};
      x_acc_d = {x_acc_q[FRAC_BITS-2:0], n_q[0]};
      y_acc_d = {y_acc_q[FRAC_BITS-2:0], dbl_cout};
      for (int i = 0; i < NDig; i++) begin
        tern_d[NDig-1-i] = dbl_res[i];
      end
    end
  end

  // subtract one half: flip the top fraction bit
  assign x_ctr = x_acc_q ^ Half;
  assign y_ctr = y_acc_q ^ Half;

  // working registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    x_acc_q <= x_acc_d;
    y_acc_q <= y_acc_d;
    for (int i = 0; i < NDig; i++) begin
      tern_q[i] <= tern_d[i];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      jx_q <= OUT_W'($signed(x_ctr));
      jy_q <= OUT_W'($signed(y_ctr));
    end
  end

  assign jitter_x_o = jx_q;
  assign jitter_y_o = jy_q;

endmodule

`default_nettype wire

>>> src/halton_jitter_generator.sv
// ----------------------------------------------------------------------------
// halton_jitter_generator: subpixel jitter from the base 2 / base 3 sequence
// Maps a frame number to a centered jitter pair in signed fixed point.
//
//   channel  dir  payload                              handshake
//   s_axis   in   frame_number                         tvalid / tready
//   m_axis   out  jitter_x, jitter_y                   tvalid / tready
//
// One request runs INDEX_BITS + 1 ternary doubling steps, FRAC_BITS fraction
// steps, and a load of the pair into the output register. The shared ternary
// doubling unit serves both phases, so the next request is taken only once
// the pair has been loaded and the sequencer is idle again.
// Reset clears the sequencer and the output valid flag only.
// A stalled output holds its pair; a new request runs meanwhile and waits
// before the output register until the pending pair is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module halton_jitter_generator #(
  parameter int unsigned INDEX_BITS = hjg_pkg::INDEX_BITS_DEF,
  parameter int unsigned FRAC_BITS  = hjg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [hjg_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,   // [15:0] frame_number
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [hjg_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o    // [15:0] jitter_x,
                                                                 // [31:16] jitter_y
);
  import hjg_pkg::*;

  hjg_cmd_t                 cmd;
  logic signed [OUT_W-1:0]  jitter_x;
  logic signed [OUT_W-1:0]  jitter_y;

  // sequencer
  hjg_ctrl #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // arithmetic
  hjg_dpath #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .frame_number_i (s_axis_tdata_i[FRAME_W-1:0]),
    .jitter_x_o     (jitter_x),
    .jitter_y_o     (jitter_y)
  );

  // result packing
  assign m_axis_tdata_o = {jitter_y, jitter_x};

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register loaded while a result is pending");

  // an accepted request keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after an accept");

  // output valid rises only after a load of the output register
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.load_out))
    else $error("result valid without a load");

endmodule

`default_nettype wire

>>> sim/tb_halton_jitter_generator.sv
// ----------------------------------------------------------------------------
// tb_halton_jitter_generator: self-checking bench for the halton jitter block
// Feeds frame numbers through the input stream, forms the expected base 2 and
// base 3 jitter pair for each accepted request by exact long division, and
// compares every returned pair in order. Runs a directed set of corner frames
// and then random frames under changing input gaps and output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_halton_jitter_generator;

  import hjg_pkg::*;

  localparam int unsigned IDX_W      = INDEX_BITS_DEF;
  localparam int unsigned FRAC_W     = FRAC_BITS_DEF;
  localparam int unsigned N_RANDOM   = 730;
  localparam int unsigned PHASE_LEN  = 120;
  localparam int unsigned DRAIN_WAIT = IDX_W + FRAC_W + 8;
  localparam int unsigned QUIET_MAX  = 2000;

  // idle pattern of both stream sides
  typedef enum logic [1:0] {
    PH_NONE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH
  } idle_phase_e;

  typedef struct {
    logic [FRAME_W-1:0]     frame;
    logic signed [OUT_W-1:0] jit_x;
    logic signed [OUT_W-1:0] jit_y;
  } jitter_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] frame_number
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [15:0] jitter_x, [31:16] jitter_y

  logic [FRAME_W-1:0] frame_queue[$];
  jitter_pair_t       jitter_expected[$];
  int unsigned        n_directed;
  int unsigned        sent_cnt    = 0;
  int unsigned        err_cnt     = 0;
  int unsigned        quiet_cycles = 0;

  halton_jitter_generator #(
    .INDEX_BITS(IDX_W),
    .FRAC_BITS (FRAC_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // floor of the radical inverse of n in the given base, FRAC_W fraction bits
  function automatic longint unsigned radical_inverse_frac(longint unsigned n,
                                                           int unsigned base);
    longint unsigned rev;
    longint unsigned pw;
    longint unsigned m;
    longint unsigned rem;
    longint unsigned q;
    rev = 0;
    pw  = 1;
    m   = n;
    q   = 0;
    while (m > 0) begin
      rev = rev * base + (m % base);
      pw  = pw * base;
      m   = m / base;
    end
    // restoring division of the reversed digits by the base power
    rem = rev;
    for (int i = 0; i < FRAC_W; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= pw) begin
        rem = rem - pw;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // expected centered jitter pair for one frame number
  function automatic jitter_pair_t predict_jitter(logic [FRAME_W-1:0] frame);
    jitter_pair_t    jp;
    longint unsigned idx;
    longint unsigned half;
    longint unsigned cx;
    longint unsigned cy;
    idx  = (longint'(frame) & ((64'd1 << IDX_W) - 1)) + 1;
    half = 64'd1 << (FRAC_W - 1);
    cx   = radical_inverse_frac(idx, 2) - half;
    cy   = radical_inverse_frac(idx, 3) - half;
    jp.frame = frame;
    jp.jit_x = cx[OUT_W-1:0];
    jp.jit_y = cy[OUT_W-1:0];
    return jp;
  endfunction

  // idle pattern follows the number of requests sent so far
  function automatic idle_phase_e current_phase(int unsigned sent);
    if (sent < n_directed) begin
      return PH_NONE;
    end
    return idle_phase_e'(((sent - n_directed) / PHASE_LEN) % 4);
  endfunction

  task automatic report_mismatch(string what, logic [FRAME_W-1:0] frame,
                                 logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("mismatch %s frame 0x%04h: got 0x%04h want 0x%04h",
             what, frame, got, want);
    err_cnt++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    idle_phase_e ph;
    logic        src_idle;
    logic        hold_off;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        jitter_expected.push_back(predict_jitter(frame_queue.pop_front()));
        sent_cnt++;
      end
      ph       = current_phase(sent_cnt);
      src_idle = ((ph == PH_SRC_IDLE) && ($urandom_range(99) < 67)) ||
                 ((ph == PH_BOTH) && ($urandom_range(99) < 8));
      // at each phase boundary wait for every pending pair to come back
      hold_off = (sent_cnt >= n_directed) &&
                 ((sent_cnt - n_directed) % PHASE_LEN == 0) &&
                 (jitter_expected.size() != 0);
      if (frame_queue.size() != 0 && !src_idle && !hold_off) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame_queue[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    jitter_pair_t exp_pair;
    idle_phase_e  ph;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (jitter_expected.size() == 0) begin
          $display("unexpected jitter pair 0x%08h", m_axis_tdata);
          err_cnt++;
        end else begin
          exp_pair = jitter_expected.pop_front();
          if (m_axis_tdata[15:0] !== exp_pair.jit_x) begin
            report_mismatch("jitter_x", exp_pair.frame, m_axis_tdata[15:0], exp_pair.jit_x);
          end
          if (m_axis_tdata[31:16] !== exp_pair.jit_y) begin
            report_mismatch("jitter_y", exp_pair.frame, m_axis_tdata[31:16],
                            exp_pair.jit_y);
          end
        end
      end
      ph = current_phase(sent_cnt);
      if (ph == PH_SINK_STALL) begin
        m_axis_tready <= ($urandom_range(99) >= 67);
      end else if (ph == PH_BOTH) begin
        m_axis_tready <= ($urandom_range(99) >= 8);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("timeout waiting for a handshake");
      $display("tb_halton_jitter_generator failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    logic [FRAME_W-1:0] corner_frames[$];
    corner_frames = '{
      16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 16'hFFFE,
      16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
      // index at an exact power of three
      16'd26, 16'd80, 16'd242, 16'd728, 16'd2186, 16'd6560, 16'd19682, 16'd59048,
      // index at an exact power of two
      16'd7, 16'd1023, 16'd32767
    };
    foreach (corner_frames[i]) begin
      frame_queue.push_back(corner_frames[i]);
    end
    n_directed = frame_queue.size();
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(9) < 2) begin
        frame_queue.push_back(FRAME_W'($urandom_range(255)));
      end else begin
        frame_queue.push_back(FRAME_W'($urandom_range(65535)));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (frame_queue.size() != 0 || s_axis_tvalid || jitter_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_halton_jitter_generator passed");
    end else begin
      $display("tb_halton_jitter_generator failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
